@@ rtl/lome_pkg.sv @@
// shared types, codes and widths of the order book engine
package lome_pkg;

    localparam int DEF_ORDER_SLOTS = 64;
    localparam int DEF_ID_BITS     = 16;
    localparam int DEF_PRICE_BITS  = 32;
    localparam int DEF_QTY_BITS    = 32;

    localparam int SEQ_W       = 48;
    localparam int OUT_ID_W    = 16;
    localparam int OUT_PRICE_W = 32;
    localparam int OUT_QTY_W   = 32;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 248;

    localparam int IN_ID_LSB    = 0;
    localparam int IN_SIDE_BIT  = 16;
    localparam int IN_PRICE_LSB = 17;
    localparam int IN_QTY_LSB   = 49;

    localparam int TRADE_W = SEQ_W + 2 * OUT_QTY_W + 2 * OUT_ID_W;

    typedef enum logic [1:0] {
        CMD_LIMIT   = 2'd0,
        CMD_MARKET  = 2'd1,
        CMD_CANCEL  = 2'd2,
        CMD_REPLACE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_ID_USED  = 3'd1,
        STAT_INACTIVE = 3'd2,
        STAT_INVALID  = 3'd3,
        STAT_NO_CHG   = 3'd4,
        STAT_FULL     = 3'd5
    } status_t;

    typedef enum logic {
        RANK_MATCH = 1'b0,
        RANK_BOOK  = 1'b1
    } rank_mode_t;

    typedef struct packed {
        logic             valid;
        logic             side;
        logic [SEQ_W-1:0] seq;
    } rank_ref_t;

endpackage

@@ rtl/lome_ram.sv @@
// generic memory with one write port and one registered read port
module lome_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/lome_rank.sv @@
// shared price and time compare unit used by the match and book sweeps
module lome_rank #(
    parameter int PRICE_BITS = lome_pkg::DEF_PRICE_BITS
) (
    input  lome_pkg::rank_mode_t        mode,
    input  logic                        taker_side,
    input  logic                        cand_valid,
    input  logic                        cand_side,
    input  logic [PRICE_BITS-1:0]       cand_price,
    input  logic [lome_pkg::SEQ_W-1:0]  cand_seq,
    input  lome_pkg::rank_ref_t         ref_info,
    input  logic [PRICE_BITS-1:0]       ref_price,
    output logic                        take
);
    import lome_pkg::*;

    logic prefer_low;
    logic side_ok;

    assign prefer_low = (mode == RANK_MATCH) ? !taker_side : cand_side;
    assign side_ok    = (mode == RANK_MATCH) ? (cand_side != taker_side) : 1'b1;

    always_comb
    begin
        priority if (!cand_valid || !side_ok)
        begin
            take = 1'b0;
        end
        else if (!ref_info.valid)
        begin
            take = 1'b1;
        end
        else if (mode == RANK_MATCH && cand_price == ref_price)
        begin
            take = cand_seq < ref_info.seq;
        end
        else
        begin
            take = prefer_low ? (cand_price < ref_price) : (cand_price > ref_price);
        end
    end
endmodule

@@ rtl/limit_order_matching_engine_top.sv @@
// Price-time priority order book. After reset the block clears all 2**ID_BITS
// entries of the used-id memory before it takes the first word. A command is
// then worked on alone, and s_tready stays low until its last result has gone.
// Each matching step is one sweep of all ORDER_SLOTS slots through the slot
// memory and the shared compare unit, then a step that books the trade.
// Cancel and replace add a sweep to find the order, a resting add remainder
// adds at most a search for a free slot and a write to fill it, and a final
// sweep forms best bid and ask. Each result then goes out through a read, a
// load and an output state, and the output state holds while m_tready is low.
module limit_order_matching_engine_top #(
    parameter int ORDER_SLOTS = lome_pkg::DEF_ORDER_SLOTS,
    parameter int ID_BITS     = lome_pkg::DEF_ID_BITS,
    parameter int PRICE_BITS  = lome_pkg::DEF_PRICE_BITS,
    parameter int QTY_BITS    = lome_pkg::DEF_QTY_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // id, side, price, quantity
    input  logic [lome_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [lome_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // buy id, sell id, trade_price, trade_quantity, trade_seq, status,
    // priority_kept, remaining, bid, ask
    output logic [lome_pkg::M_TDATA_W-1:0] m_tdata,
    // has_trade
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import lome_pkg::*;

    localparam int IDX_W = $clog2(ORDER_SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = ID_BITS + 1 + PRICE_BITS + 2 * QTY_BITS + SEQ_W;
    localparam int MAP_DEPTH = 1 << ID_BITS;
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(ORDER_SLOTS);
    localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(ORDER_SLOTS - 1);

    typedef enum logic [13:0] {
        ST_CLEAR     = 14'b00000000000001,
        ST_IDLE      = 14'b00000000000010,
        ST_ID_RD     = 14'b00000000000100,
        ST_ADD_CHK   = 14'b00000000001000,
        ST_FIND      = 14'b00000000010000,
        ST_FIND_DONE = 14'b00000000100000,
        ST_MSCAN     = 14'b00000001000000,
        ST_MSTEP     = 14'b00000010000000,
        ST_FREE      = 14'b00000100000000,
        ST_PLACE     = 14'b00001000000000,
        ST_BSCAN     = 14'b00010000000000,
        ST_EMIT_RD   = 14'b00100000000000,
        ST_EMIT_LD   = 14'b01000000000000,
        ST_EMIT_OUT  = 14'b10000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;
    logic [ID_BITS-1:0]     clr_reg, clr_next;
    logic [CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                   pv_reg, pv_next;
    logic [IDX_W-1:0]       pidx_reg, pidx_next;
    logic [SEQ_W-1:0]       oseq_reg, oseq_next;
    logic [SEQ_W-1:0]       tseq_reg, tseq_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       emit_idx_reg, emit_idx_next;
    logic                   best_v_reg, best_v_next;
    logic                   hb_reg, hb_next;
    logic                   ha_reg, ha_next;

    cmd_t                   cmd_reg, cmd_next;
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic                   side_reg, side_next;
    logic [PRICE_BITS-1:0]  price_reg, price_next;
    logic [QTY_BITS-1:0]    qty_reg, qty_next;
    logic                   limited_reg, limited_next;
    logic [QTY_BITS-1:0]    rem_reg, rem_next;
    status_t                status_reg, status_next;
    logic                   kept_reg, kept_next;
    logic [SEQ_W-1:0]       pseq_reg, pseq_next;
    logic [IDX_W-1:0]       place_idx_reg, place_idx_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [ID_BITS-1:0]     best_id_reg, best_id_next;
    logic                   best_side_reg, best_side_next;
    logic [PRICE_BITS-1:0]  best_price_reg, best_price_next;
    logic [QTY_BITS-1:0]    best_orig_reg, best_orig_next;
    logic [QTY_BITS-1:0]    best_filled_reg, best_filled_next;
    logic [SEQ_W-1:0]       best_seq_reg, best_seq_next;
    logic [PRICE_BITS-1:0]  bb_reg, bb_next;
    logic [PRICE_BITS-1:0]  ba_reg, ba_next;
    logic [TRADE_W-1:0]     o_trade_reg, o_trade_next;
    logic                   o_has_reg, o_has_next;
    logic                   o_last_reg, o_last_next;
    status_t                o_status_reg, o_status_next;

    logic                   slot_we;
    logic [IDX_W-1:0]       slot_waddr;
    logic [ENT_W-1:0]       slot_wdata;
    logic [ENT_W-1:0]       slot_rdata;
    logic [ID_BITS-1:0]     r_id;
    logic                   r_side;
    logic [PRICE_BITS-1:0]  r_price;
    logic [QTY_BITS-1:0]    r_orig;
    logic [QTY_BITS-1:0]    r_filled;
    logic [SEQ_W-1:0]       r_seq;

    logic                   map_we;
    logic [ID_BITS-1:0]     map_waddr;
    logic [0:0]             map_wdata;
    logic [0:0]             map_rdata;

    logic                   tr_we;
    logic [TRADE_W-1:0]     tr_wdata;
    logic [TRADE_W-1:0]     tr_rdata;

    rank_mode_t             rank_mode;
    rank_ref_t              rank_ref;
    logic [PRICE_BITS-1:0]  rank_ref_price;
    logic                   take;

    logic [QTY_BITS-1:0]    rq;
    logic [QTY_BITS-1:0]    q;
    logic [QTY_BITS-1:0]    rem_after;
    logic [QTY_BITS-1:0]    filled_new;
    logic                   crosses;
    logic [ID_BITS-1:0]     buy_id;
    logic [ID_BITS-1:0]     sell_id;
    logic                   scan_done;
    logic                   same_px;
    logic                   pres;

    lome_ram #(.WIDTH(ENT_W), .DEPTH(ORDER_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (slot_rdata)
    );

    lome_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (id_reg),
        .rdata (map_rdata)
    );

    lome_ram #(.WIDTH(TRADE_W), .DEPTH(ORDER_SLOTS)) u_trade_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata (tr_wdata),
        .raddr (emit_idx_reg),
        .rdata (tr_rdata)
    );

    assign {r_id, r_side, r_price, r_orig, r_filled, r_seq} = slot_rdata;

    assign rank_mode      = (state_reg == ST_BSCAN) ? RANK_BOOK : RANK_MATCH;
    assign rank_ref.side  = r_side;
    assign rank_ref.seq   = best_seq_reg;
    assign rank_ref.valid = (state_reg == ST_BSCAN) ? (r_side ? ha_reg : hb_reg) : best_v_reg;
    assign rank_ref_price = (state_reg == ST_BSCAN) ? (r_side ? ba_reg : bb_reg)
                                                    : best_price_reg;

    lome_rank #(.PRICE_BITS(PRICE_BITS)) u_rank (
        .mode       (rank_mode),
        .taker_side (side_reg),
        .cand_valid (valid_reg[pidx_reg]),
        .cand_side  (r_side),
        .cand_price (r_price),
        .cand_seq   (r_seq),
        .ref_info   (rank_ref),
        .ref_price  (rank_ref_price),
        .take       (take)
    );

    assign rq         = best_orig_reg - best_filled_reg;
    assign q          = (rem_reg < rq) ? rem_reg : rq;
    assign rem_after  = rem_reg - q;
    assign filled_new = best_filled_reg + q;
    assign crosses    = !limited_reg || (side_reg ? (best_price_reg >= price_reg)
                                                  : (best_price_reg <= price_reg));
    assign buy_id     = side_reg ? best_id_reg : id_reg;
    assign sell_id    = side_reg ? id_reg : best_id_reg;
    assign scan_done  = (scan_cnt_reg == SLOT_CNT) && !pv_reg;
    assign same_px    = price_reg == best_price_reg;
    assign pres       = same_px && (qty_reg < best_orig_reg);

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        clr_next         = clr_reg;
        scan_cnt_next    = scan_cnt_reg;
        pv_next          = pv_reg;
        pidx_next        = pidx_reg;
        oseq_next        = oseq_reg;
        tseq_next        = tseq_reg;
        n_next           = n_reg;
        emit_idx_next    = emit_idx_reg;
        best_v_next      = best_v_reg;
        hb_next          = hb_reg;
        ha_next          = ha_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        side_next        = side_reg;
        price_next       = price_reg;
        qty_next         = qty_reg;
        limited_next     = limited_reg;
        rem_next         = rem_reg;
        status_next      = status_reg;
        kept_next        = kept_reg;
        pseq_next        = pseq_reg;
        place_idx_next   = place_idx_reg;
        best_idx_next    = best_idx_reg;
        best_id_next     = best_id_reg;
        best_side_next   = best_side_reg;
        best_price_next  = best_price_reg;
        best_orig_next   = best_orig_reg;
        best_filled_next = best_filled_reg;
        best_seq_next    = best_seq_reg;
        bb_next          = bb_reg;
        ba_next          = ba_reg;
        o_trade_next     = o_trade_reg;
        o_has_next       = o_has_reg;
        o_last_next      = o_last_reg;
        o_status_next    = o_status_reg;
        slot_we          = 1'b0;
        slot_waddr       = best_idx_reg;
        slot_wdata       = {best_id_reg, best_side_reg, best_price_reg, best_orig_reg,
                            filled_new, best_seq_reg};
        map_we           = 1'b0;
        map_waddr        = id_reg;
        map_wdata        = 1'b1;
        tr_we            = 1'b0;
        tr_wdata         = {tseq_reg, OUT_QTY_W'(q), OUT_PRICE_W'(best_price_reg),
                            OUT_ID_W'(sell_id), OUT_ID_W'(buy_id)};

        // sweep address generator
        if (state_reg == ST_FIND || state_reg == ST_MSCAN || state_reg == ST_BSCAN)
        begin
            if (scan_cnt_reg < SLOT_CNT)
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                pv_next       = 1'b1;
                pidx_next     = scan_cnt_reg[IDX_W-1:0];
            end
            else
            begin
                pv_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {ID_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next      = cmd_t'(s_tuser);
                    id_next       = ID_BITS'(s_tdata[IN_ID_LSB +: OUT_ID_W]);
                    side_next     = s_tdata[IN_SIDE_BIT];
                    price_next    = s_tdata[IN_PRICE_LSB +: PRICE_BITS];
                    qty_next      = s_tdata[IN_QTY_LSB +: QTY_BITS];
                    n_next        = '0;
                    emit_idx_next = '0;
                    status_next   = STAT_OK;
                    kept_next     = 1'b0;
                    rem_next      = '0;
                    if (cmd_t'(s_tuser) == CMD_LIMIT || cmd_t'(s_tuser) == CMD_MARKET)
                    begin
                        state_next = ST_ID_RD;
                    end
                    else
                    begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_ID_RD:
            begin
                state_next = ST_ADD_CHK;
            end
            ST_ADD_CHK:
            begin
                priority if (map_rdata[0])
                begin
                    status_next = STAT_ID_USED;
                    state_next  = ST_BSCAN;
                end
                else if (qty_reg == '0 || (cmd_reg == CMD_LIMIT && price_reg == '0))
                begin
                    status_next = STAT_INVALID;
                    state_next  = ST_BSCAN;
                end
                else
                begin
                    map_we       = 1'b1;
                    pseq_next    = oseq_reg;
                    oseq_next    = oseq_reg + 1'b1;
                    rem_next     = qty_reg;
                    limited_next = cmd_reg == CMD_LIMIT;
                    state_next   = ST_MSCAN;
                end
            end
            ST_FIND, ST_MSCAN:
            begin
                if (pv_reg && ((state_reg == ST_FIND) ? (valid_reg[pidx_reg] && r_id == id_reg)
                                                      : take))
                begin
                    best_v_next      = 1'b1;
                    best_idx_next    = pidx_reg;
                    best_id_next     = r_id;
                    best_side_next   = r_side;
                    best_price_next  = r_price;
                    best_orig_next   = r_orig;
                    best_filled_next = r_filled;
                    best_seq_next    = r_seq;
                end
                if (scan_done)
                begin
                    state_next = (state_reg == ST_FIND) ? ST_FIND_DONE : ST_MSTEP;
                end
            end
            ST_FIND_DONE:
            begin
                state_next     = ST_BSCAN;
                place_idx_next = best_idx_reg;
                slot_waddr     = best_idx_reg;
                priority if (!best_v_reg)
                begin
                    status_next = STAT_INACTIVE;
                end
                else if (cmd_reg == CMD_CANCEL)
                begin
                    rem_next                 = best_orig_reg - best_filled_reg;
                    valid_next[best_idx_reg] = 1'b0;
                end
                else if (price_reg == '0 || qty_reg < best_filled_reg)
                begin
                    status_next = STAT_INVALID;
                end
                else if (same_px && qty_reg == best_orig_reg)
                begin
                    status_next = STAT_NO_CHG;
                end
                else if (pres && qty_reg > best_filled_reg)
                begin
                    kept_next  = 1'b1;
                    slot_we    = 1'b1;
                    slot_wdata = {best_id_reg, best_side_reg, best_price_reg, qty_reg,
                                  best_filled_reg, best_seq_reg};
                    rem_next   = qty_reg - best_filled_reg;
                end
                else if (same_px && qty_reg > best_orig_reg)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {best_id_reg, best_side_reg, best_price_reg, qty_reg,
                                  best_filled_reg, oseq_reg};
                    oseq_next  = oseq_reg + 1'b1;
                    rem_next   = qty_reg - best_filled_reg;
                end
                else
                begin
                    kept_next                = pres;
                    valid_next[best_idx_reg] = 1'b0;
                    side_next                = best_side_reg;
                    limited_next             = 1'b1;
                    if (pres)
                    begin
                        pseq_next = best_seq_reg;
                    end
                    else
                    begin
                        pseq_next = oseq_reg;
                        oseq_next = oseq_reg + 1'b1;
                    end
                    if (qty_reg > best_filled_reg)
                    begin
                        rem_next   = qty_reg - best_filled_reg;
                        state_next = ST_MSCAN;
                    end
                end
            end
            ST_MSTEP:
            begin
                if (best_v_reg && crosses)
                begin
                    tr_we     = 1'b1;
                    slot_we   = 1'b1;
                    tseq_next = tseq_reg + 1'b1;
                    n_next    = n_reg + 1'b1;
                    rem_next  = rem_after;
                    if (q == rq)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    priority if (rem_after != '0 && (n_reg + 1'b1) != SLOT_CNT)
                    begin
                        state_next = ST_MSCAN;
                    end
                    else if (rem_after != '0 && limited_reg)
                    begin
                        state_next = (cmd_reg == CMD_REPLACE) ? ST_PLACE : ST_FREE;
                    end
                    else
                    begin
                        state_next = ST_BSCAN;
                    end
                end
                else if (rem_reg != '0 && limited_reg)
                begin
                    state_next = (cmd_reg == CMD_REPLACE) ? ST_PLACE : ST_FREE;
                end
                else
                begin
                    state_next = ST_BSCAN;
                end
            end
            ST_FREE:
            begin
                priority if (!valid_reg[scan_cnt_reg[IDX_W-1:0]])
                begin
                    place_idx_next = scan_cnt_reg[IDX_W-1:0];
                    state_next     = ST_PLACE;
                end
                else if (scan_cnt_reg == SLOT_LAST)
                begin
                    status_next = STAT_FULL;
                    state_next  = ST_BSCAN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_PLACE:
            begin
                slot_we                   = 1'b1;
                slot_waddr                = place_idx_reg;
                slot_wdata                = {id_reg, side_reg, price_reg, qty_reg,
                                             qty_reg - rem_reg, pseq_reg};
                valid_next[place_idx_reg] = 1'b1;
                state_next                = ST_BSCAN;
            end
            ST_BSCAN:
            begin
                if (pv_reg && take)
                begin
                    if (r_side)
                    begin
                        ha_next = 1'b1;
                        ba_next = r_price;
                    end
                    else
                    begin
                        hb_next = 1'b1;
                        bb_next = r_price;
                    end
                end
                if (scan_done)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                o_has_next    = n_reg != '0;
                o_trade_next  = (n_reg != '0) ? tr_rdata : '0;
                o_last_next   = (n_reg == '0) || ({1'b0, emit_idx_reg} + 1'b1 == n_reg);
                o_status_next = o_last_next ? status_reg : STAT_OK;
                state_next    = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (m_tready)
                begin
                    if (o_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // fresh sweep on entry
        if (state_next != state_reg && (state_next == ST_FIND || state_next == ST_MSCAN ||
                                        state_next == ST_BSCAN || state_next == ST_FREE))
        begin
            scan_cnt_next = '0;
            pv_next       = 1'b0;
            best_v_next   = 1'b0;
            hb_next       = 1'b0;
            ha_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            valid_reg    <= '0;
            clr_reg      <= '0;
            scan_cnt_reg <= '0;
            pv_reg       <= 1'b0;
            oseq_reg     <= '0;
            tseq_reg     <= '0;
            n_reg        <= '0;
            emit_idx_reg <= '0;
            best_v_reg   <= 1'b0;
            hb_reg       <= 1'b0;
            ha_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            clr_reg      <= clr_next;
            scan_cnt_reg <= scan_cnt_next;
            pv_reg       <= pv_next;
            oseq_reg     <= oseq_next;
            tseq_reg     <= tseq_next;
            n_reg        <= n_next;
            emit_idx_reg <= emit_idx_next;
            best_v_reg   <= best_v_next;
            hb_reg       <= hb_next;
            ha_reg       <= ha_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg        <= pidx_next;
        cmd_reg         <= cmd_next;
        id_reg          <= id_next;
        side_reg        <= side_next;
        price_reg       <= price_next;
        qty_reg         <= qty_next;
        limited_reg     <= limited_next;
        rem_reg         <= rem_next;
        status_reg      <= status_next;
        kept_reg        <= kept_next;
        pseq_reg        <= pseq_next;
        place_idx_reg   <= place_idx_next;
        best_idx_reg    <= best_idx_next;
        best_id_reg     <= best_id_next;
        best_side_reg   <= best_side_next;
        best_price_reg  <= best_price_next;
        best_orig_reg   <= best_orig_next;
        best_filled_reg <= best_filled_next;
        best_seq_reg    <= best_seq_next;
        bb_reg          <= bb_next;
        ba_reg          <= ba_next;
        o_trade_reg     <= o_trade_next;
        o_has_reg       <= o_has_next;
        o_last_reg      <= o_last_next;
        o_status_reg    <= o_status_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_EMIT_OUT;
    assign m_tuser  = o_has_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = M_TDATA_W'({OUT_PRICE_W'(ha_reg ? ba_reg : '0),
                                  OUT_PRICE_W'(hb_reg ? bb_reg : '0),
                                  OUT_QTY_W'(rem_reg), kept_reg, o_status_reg, o_trade_reg});

    a_place_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PLACE |-> !valid_reg[place_idx_reg])
        else $error("placing into a slot that is in use");

    a_best_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MSTEP && best_v_reg |-> valid_reg[best_idx_reg])
        else $error("matched slot is not resting");

    a_trade_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MSTEP |-> n_reg < SLOT_CNT)
        else $error("trade buffer overrun");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("status-only word not marked last");

endmodule

@@ tb/limit_order_matching_engine_top_tb.sv @@
// testbench for the order book engine: random and directed commands against a built-in book model
`timescale 1ns / 1ps

module limit_order_matching_engine_top_tb;
    import lome_pkg::*;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        bit          drain;
    } order_cmd_t;

    typedef struct {
        logic        has_trade;
        logic [15:0] buy_id;
        logic [15:0] sell_id;
        logic [31:0] tprice;
        logic [31:0] tqty;
        logic [47:0] tseq;
        status_t     status;
        logic        kept;
        logic [31:0] remaining;
        logic [31:0] bid;
        logic [31:0] ask;
        logic        last;
    } fill_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    limit_order_matching_engine_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // book copy
    bit          bk_valid [SLOTS];
    logic [15:0] bk_id    [SLOTS];
    logic        bk_side  [SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic [31:0] bk_orig  [SLOTS];
    logic [31:0] bk_fill  [SLOTS];
    logic [47:0] bk_seq   [SLOTS];
    bit          id_taken [65536];
    logic [47:0] order_seq_ctr;
    logic [47:0] trade_seq_ctr;

    order_cmd_t  pending[$];
    fill_t       fills_due[$];
    order_cmd_t  cur;
    bit          taken;
    int          errors;
    int          words_sent;
    int          idle_cycles;

    // generator side view of resting orders
    logic [15:0] gen_ids[$];
    logic [31:0] gen_price[logic [15:0]];
    logic [31:0] gen_qty[logic [15:0]];
    int          next_fresh;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int slot_of(logic [15:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (bk_valid[i] && bk_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void cross_book(input logic [15:0] id, input logic side,
                                       input bit limited, input logic [31:0] limit,
                                       inout logic [31:0] rem, inout fill_t trades[$]);
        int best;
        logic [31:0] q;
        logic [31:0] rq;
        fill_t t;
        while (rem > 0 && trades.size() < SLOTS)
        begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!bk_valid[i] || bk_side[i] == side)
                    continue;
                if (best < 0)
                    best = i;
                else if (bk_price[i] == bk_price[best])
                begin
                    if (bk_seq[i] < bk_seq[best])
                        best = i;
                end
                else if (side == 1'b0 ? bk_price[i] < bk_price[best]
                                      : bk_price[i] > bk_price[best])
                    best = i;
            end
            if (best < 0)
                break;
            if (limited && (side == 1'b0 ? bk_price[best] > limit : bk_price[best] < limit))
                break;
            rq = bk_orig[best] - bk_fill[best];
            q = rem < rq ? rem : rq;
            t = '{status: STAT_OK, default: '0};
            t.has_trade = 1'b1;
            t.buy_id = side == 1'b0 ? id : bk_id[best];
            t.sell_id = side == 1'b0 ? bk_id[best] : id;
            t.tprice = bk_price[best];
            t.tqty = q;
            t.tseq = trade_seq_ctr;
            trade_seq_ctr = trade_seq_ctr + 1'b1;
            bk_fill[best] = bk_fill[best] + q;
            rem = rem - q;
            if (bk_fill[best] >= bk_orig[best])
                bk_valid[best] = 0;
            trades.insert(trades.size(), t);
        end
    endfunction

    function automatic bit rest_order(int s, logic [15:0] id, logic side, logic [31:0] price,
                                      logic [31:0] orig, logic [31:0] filled, logic [47:0] seq);
        if (s < 0)
            for (int i = 0; i < SLOTS; i++)
                if (!bk_valid[i])
                begin
                    s = i;
                    break;
                end
        if (s < 0)
            return 0;
        bk_valid[s] = 1;
        bk_id[s] = id;
        bk_side[s] = side;
        bk_price[s] = price;
        bk_orig[s] = orig;
        bk_fill[s] = filled;
        bk_seq[s] = seq;
        return 1;
    endfunction

    function automatic void book_step(order_cmd_t c);
        fill_t       trades[$];
        fill_t       f;
        status_t     st;
        logic        kept;
        logic [31:0] rem;
        logic [31:0] bb;
        logic [31:0] ba;
        logic [31:0] orig;
        logic [31:0] filled;
        logic [47:0] seq;
        logic        sd;
        bit          hb;
        bit          ha;
        bit          same;
        bit          pres;
        int          s;
        st = STAT_OK;
        kept = 1'b0;
        rem = '0;
        bb = '0;
        ba = '0;
        hb = 0;
        ha = 0;
        if (c.cmd == CMD_LIMIT || c.cmd == CMD_MARKET)
        begin
            if (id_taken[c.id])
                st = STAT_ID_USED;
            else if (c.qty == 0 || (c.cmd == CMD_LIMIT && c.price == 0))
                st = STAT_INVALID;
            else
            begin
                id_taken[c.id] = 1;
                seq = order_seq_ctr;
                order_seq_ctr = order_seq_ctr + 1'b1;
                rem = c.qty;
                cross_book(c.id, c.side, c.cmd == CMD_LIMIT, c.price, rem, trades);
                if (c.cmd == CMD_LIMIT && rem > 0 &&
                    !rest_order(-1, c.id, c.side, c.price, c.qty, c.qty - rem, seq))
                    st = STAT_FULL;
            end
        end
        else if (c.cmd == CMD_CANCEL)
        begin
            s = slot_of(c.id);
            if (s < 0)
                st = STAT_INACTIVE;
            else
            begin
                rem = bk_orig[s] - bk_fill[s];
                bk_valid[s] = 0;
            end
        end
        else
        begin
            s = slot_of(c.id);
            if (s < 0)
                st = STAT_INACTIVE;
            else
            begin
                orig = bk_orig[s];
                filled = bk_fill[s];
                same = c.price == bk_price[s];
                if (c.price == 0 || c.qty < filled)
                    st = STAT_INVALID;
                else if (same && c.qty == orig)
                    st = STAT_NO_CHG;
                else
                begin
                    pres = same && c.qty < orig;
                    kept = pres;
                    if (pres && c.qty > filled)
                    begin
                        bk_orig[s] = c.qty;
                        rem = c.qty - filled;
                    end
                    else if (same && c.qty > orig)
                    begin
                        bk_orig[s] = c.qty;
                        bk_seq[s] = order_seq_ctr;
                        order_seq_ctr = order_seq_ctr + 1'b1;
                        rem = c.qty - filled;
                    end
                    else
                    begin
                        if (pres)
                            seq = bk_seq[s];
                        else
                        begin
                            seq = order_seq_ctr;
                            order_seq_ctr = order_seq_ctr + 1'b1;
                        end
                        sd = bk_side[s];
                        bk_valid[s] = 0;
                        if (c.qty > filled)
                        begin
                            rem = c.qty - filled;
                            cross_book(c.id, sd, 1, c.price, rem, trades);
                            if (rem > 0)
                                void'(rest_order(s, c.id, sd, c.price, c.qty, c.qty - rem, seq));
                        end
                    end
                end
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!bk_valid[i])
                continue;
            if (bk_side[i] == 1'b0)
            begin
                if (!hb || bk_price[i] > bb)
                begin
                    bb = bk_price[i];
                    hb = 1;
                end
            end
            else if (!ha || bk_price[i] < ba)
            begin
                ba = bk_price[i];
                ha = 1;
            end
        end
        if (trades.size() == 0)
        begin
            f = '{status: STAT_OK, default: '0};
            trades.insert(0, f);
        end
        foreach (trades[k])
        begin
            f = trades[k];
            f.last = k == trades.size() - 1;
            f.status = f.last ? st : STAT_OK;
            f.kept = kept;
            f.remaining = rem;
            f.bid = bb;
            f.ask = ba;
            fills_due.insert(fills_due.size(), f);
        end
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit calm();
        return words_sent >= 120 && words_sent < 220;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            book_step(cur);
            words_sent++;
            taken = 1;
        end
    end

    always @(negedge clk)
    begin
        logic nv;
        if (rst_n)
        begin
            nv = s_tvalid && !taken;
            if (!nv && pending.size() != 0 && (calm() || $urandom_range(0, 99) >= 38) &&
                !(pending[0].drain && fills_due.size() != 0))
            begin
                cur = pending.pop_front();
                s_tdata <= {7'd0, cur.qty, cur.price, cur.side, cur.id};
                s_tuser <= cur.cmd;
                nv = 1'b1;
            end
            s_tvalid <= nv;
            m_tready <= calm() || $urandom_range(0, 99) >= 38;
            taken = 0;
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        fill_t w;
        if (rst_n)
        begin
            idle_cycles++;
            if (s_tvalid && s_tready)
                idle_cycles = 0;
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                if (fills_due.size() == 0)
                    report("unexpected word", m_tdata[63:0], 0);
                else
                begin
                    w = fills_due.pop_front();
                    if (m_tuser !== w.has_trade) report("has_trade", m_tuser, w.has_trade);
                    if (m_tdata[15:0] !== w.buy_id) report("buy_id", m_tdata[15:0], w.buy_id);
                    if (m_tdata[31:16] !== w.sell_id)
                        report("sell_id", m_tdata[31:16], w.sell_id);
                    if (m_tdata[63:32] !== w.tprice)
                        report("trade_price", m_tdata[63:32], w.tprice);
                    if (m_tdata[95:64] !== w.tqty)
                        report("trade_quantity", m_tdata[95:64], w.tqty);
                    if (m_tdata[143:96] !== w.tseq)
                        report("trade_seq", m_tdata[143:96], w.tseq);
                    if (m_tdata[146:144] !== w.status)
                        report("status", m_tdata[146:144], w.status);
                    if (m_tdata[147] !== w.kept) report("priority_kept", m_tdata[147], w.kept);
                    if (m_tdata[179:148] !== w.remaining)
                        report("remaining", m_tdata[179:148], w.remaining);
                    if (m_tdata[211:180] !== w.bid) report("bid", m_tdata[211:180], w.bid);
                    if (m_tdata[243:212] !== w.ask) report("ask", m_tdata[243:212], w.ask);
                    if (m_tlast !== w.last) report("last", m_tlast, w.last);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic void add_cmd(cmd_t cmd, logic [15:0] id, logic side,
                                    logic [31:0] price, logic [31:0] qty, bit drain = 0);
        order_cmd_t c;
        c = '{cmd, id, side, price, qty, drain};
        pending.insert(pending.size(), c);
        if (cmd == CMD_LIMIT)
        begin
            gen_ids.insert(gen_ids.size(), id);
            gen_price[id] = price;
            gen_qty[id] = qty;
        end
    endfunction

    function automatic logic [31:0] pick_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 8)
            return $urandom();
        return 100 + $urandom_range(0, 15);
    endfunction

    function automatic logic [31:0] pick_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 8)
            return $urandom();
        return $urandom_range(1, 40);
    endfunction

    function automatic logic [15:0] pick_live();
        int n;
        n = gen_ids.size();
        if (n == 0 || $urandom_range(0, 19) == 0)
            return 16'($urandom());
        return gen_ids[$urandom_range(n > 40 ? n - 40 : 0, n - 1)];
    endfunction

    initial
    begin
        logic [15:0] id;
        logic [31:0] p;
        int r;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        taken = 0;
        errors = 0;
        words_sent = 0;
        idle_cycles = 0;
        order_seq_ctr = '0;
        trade_seq_ctr = '0;
        next_fresh = 10;

        // directed part
        add_cmd(CMD_LIMIT, 16'd0, 1'b0, 32'd100, 32'd10);
        add_cmd(CMD_LIMIT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(CMD_LIMIT, 16'd1, 1'b1, 32'd100, 32'd4);
        add_cmd(CMD_LIMIT, 16'd1, 1'b0, 32'd100, 32'd4);
        add_cmd(CMD_LIMIT, 16'd5, 1'b0, 32'd100, 32'd0);
        add_cmd(CMD_LIMIT, 16'd5, 1'b1, 32'd0, 32'd7);
        add_cmd(CMD_MARKET, 16'd2, 1'b0, 32'd0, 32'd3);
        add_cmd(CMD_CANCEL, 16'd500, 1'b0, 32'd0, 32'd0);
        add_cmd(CMD_REPLACE, 16'd500, 1'b0, 32'd100, 32'd5);
        add_cmd(CMD_REPLACE, 16'd0, 1'b0, 32'd100, 32'd10);
        add_cmd(CMD_REPLACE, 16'd0, 1'b0, 32'd100, 32'd8);
        add_cmd(CMD_REPLACE, 16'd0, 1'b0, 32'd100, 32'd12);
        add_cmd(CMD_REPLACE, 16'd0, 1'b0, 32'd0, 32'd12);
        add_cmd(CMD_REPLACE, 16'd0, 1'b0, 32'd100, 32'd1);
        add_cmd(CMD_REPLACE, 16'd0, 1'b0, 32'd101, 32'd12);
        add_cmd(CMD_REPLACE, 16'd0, 1'b0, 32'd101, 32'd4);
        add_cmd(CMD_CANCEL, 16'hFFFF, 1'b1, 32'd0, 32'd0);
        add_cmd(CMD_MARKET, 16'd3, 1'b1, 32'd0, 32'd5);
        add_cmd(CMD_MARKET, 16'd4, 1'b1, 32'd0, 32'd0);
        add_cmd(CMD_LIMIT, 16'd6, 1'b1, 32'd105, 32'd6);
        add_cmd(CMD_LIMIT, 16'd7, 1'b0, 32'd110, 32'd20);

        // random part
        for (int k = 0; k < 360; k++)
        begin
            if (k == 200)
            begin
                // fill every slot, overflow, then sweep the bids
                for (int j = 0; j < 70; j++)
                begin
                    add_cmd(CMD_LIMIT, 16'(next_fresh), 1'b0, 32'(10 + $urandom_range(0, 9)),
                            $urandom_range(1, 40), j == 0);
                    next_fresh++;
                end
                for (int j = 0; j < 2; j++)
                begin
                    add_cmd(CMD_MARKET, 16'(next_fresh), 1'b1, 32'd0, 32'd100000);
                    next_fresh++;
                end
            end
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                if ($urandom_range(0, 29) == 0)
                    id = pick_live();
                else
                begin
                    id = 16'(next_fresh);
                    next_fresh++;
                end
                add_cmd(CMD_LIMIT, id, 1'($urandom_range(0, 1)), pick_price(), pick_qty());
            end
            else if (r < 62)
            begin
                add_cmd(CMD_MARKET, 16'(next_fresh), 1'($urandom_range(0, 1)), $urandom(),
                        pick_qty());
                next_fresh++;
            end
            else if (r < 77)
                add_cmd(CMD_CANCEL, pick_live(), 1'($urandom_range(0, 1)), $urandom(),
                        $urandom());
            else
            begin
                id = pick_live();
                r = $urandom_range(0, 99);
                p = (r < 50 && gen_price.exists(id)) ? gen_price[id] : pick_price();
                if (r < 50 && gen_qty.exists(id))
                    add_cmd(CMD_REPLACE, id, 1'($urandom_range(0, 1)), p,
                            gen_qty[id] + $urandom_range(0, 6) - 3);
                else
                    add_cmd(CMD_REPLACE, id, 1'($urandom_range(0, 1)), p, pick_qty());
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || s_tvalid || fills_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && fills_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
